[hw/rtl/assert_macros.svh]
// assertion helpers, sampled on the rising edge of clk, off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/lsg_pkg.sv]
`default_nettype none

package lsg_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAFE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_END  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP = 3'd4;

  // register reset values
  localparam logic [15:0]        CRITICAL_RST = 16'd600;
  localparam logic [15:0]        SAFE_RST     = 16'd5000;
  localparam logic signed [15:0] START_RST    = -16'sd9651;
  localparam logic signed [15:0] END_RST      = 16'sd9651;
  localparam logic [11:0]        STEP_RST     = 12'd24;

  // fixed formats
  localparam int GAUGE_W    = 16;
  localparam int WEIGHTED_W = 19;
  localparam logic [15:0]           TWO_OVER_PI_Q16 = 16'd41722;
  localparam logic [WEIGHTED_W-1:0] WEIGHTED_MAX    = '1;
  localparam logic [GAUGE_W-1:0]    GAUGE_MAX       = '1;
  localparam logic [3:0]            DIV_STEPS_M1    = 4'd15;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic diff_en;
    logic wgt_en;
    logic mul_en;
    logic min_en;
    logic setup;
    logic div_step;
    logic load_out;
  } lsg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
    logic gauge_trivial;
    logic div_done;
    logic out_busy;
  } lsg_sts_t;

endpackage

`default_nettype wire

[hw/rtl/lsg_if.sv]
`default_nettype none

// sample channel
interface lsg_in_if #(
  parameter int RANGE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [RANGE_BITS-1:0] range_mm;
  logic                  last_sample;

  modport source (output valid, output range_mm, output last_sample, input ready);
  modport sink   (input valid, input range_mm, input last_sample, output ready);
endinterface

// result channel
interface lsg_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] safety_level;
  logic [18:0] nearest_weighted_mm;

  modport source (output valid, output safety_level, output nearest_weighted_mm, input ready);
  modport sink   (input valid, input safety_level, input nearest_weighted_mm, output ready);
endinterface

`default_nettype wire

[hw/rtl/lidar_safety_gauge.sv]
`default_nettype none

// Lidar safety gauge. Range samples of one scan stream in on in_ch; the
// beam angle starts at the configured start angle and grows by the step,
// saturating at the top of the 16 bit range. Each range is weighted by
// 1 + (2/pi)*|angle - centre| and the minimum weighted range is kept. The
// sample flagged last produces one result: that minimum and a Q0.16 gauge
// of where it sits between the critical and safe radii. A sample passes
// capture, centre distance, weight multiply and range multiply; the
// minimum update overlaps the next capture. A last sample then takes the
// minimum update, a setup step and, unless the gauge is clamped, the
// bit-serial divider, then the output register load, which a pending
// result holds until out_ch.ready. The user puts register writes in only
// while idle; the block does not enforce it. They apply from the next sample.
module lidar_safety_gauge #(
  parameter int RANGE_BITS      = 16,
  parameter int ANGLE_FRAC_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  lsg_in_if.sink                         in_ch,
  lsg_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [lsg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lsg_pkg::*;

  `include "assert_macros.svh"

  lsg_cmd_t cmd;
  lsg_sts_t sts;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  lsg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lsg_datapath #(
    .RANGE_BITS      (RANGE_BITS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_datapath (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .sts                     (sts),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata),
    .in_range_mm             (in_ch.range_mm),
    .in_last_sample          (in_ch.last_sample),
    .out_ready               (out_ch.ready),
    .out_valid               (out_ch.valid),
    .out_safety_level        (out_ch.safety_level),
    .out_nearest_weighted_mm (out_ch.nearest_weighted_mm)
  );

  // a request starts its pipeline walk, so no sample follows in the next cycle
  `ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ready, !in_ready, "sample taken while busy")

  // a new result never overwrites one still waiting
  `ASSERT_SAME(a_no_overwrite, cmd.load_out, !(out_ch.valid && !out_ch.ready), "result overwritten")

  // no sample is taken while the divider runs
  `ASSERT_SAME(a_div_blocks_input, cmd.div_step, !in_ready, "sample taken during divide")

  // a result appears only from the load command
  `ASSERT_SAME(a_result_source, $rose(out_ch.valid), $past(cmd.load_out), "result without load")

endmodule

`default_nettype wire

[hw/rtl/lsg_ctrl.sv]
`default_nettype none

module lsg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lsg_pkg::lsg_sts_t sts,
  output lsg_pkg::lsg_cmd_t cmd
);
  import lsg_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_DIFF  = 8'b0000_0010,
    ST_WGT   = 8'b0000_0100,
    ST_MUL   = 8'b0000_1000,
    ST_MIN   = 8'b0001_0000,
    ST_SETUP = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // a new sample enters when idle or while the previous non-last one folds into the minimum
  assign in_ready = (state_r == ST_IDLE) || ((state_r == ST_MIN) && !sts.last);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.accept = in_valid && in_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff_en = 1'b1;
        state_nxt   = ST_WGT;
      end
      ST_WGT: begin
        cmd.wgt_en = 1'b1;
        state_nxt  = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_MIN;
      end
      ST_MIN: begin
        cmd.min_en = 1'b1;
        if (sts.last) state_nxt = ST_SETUP;
        else if (in_valid) state_nxt = ST_DIFF;
        else state_nxt = ST_IDLE;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = sts.gauge_trivial ? ST_EMIT : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/lsg_datapath.sv]
`default_nettype none

module lsg_datapath #(
  parameter int RANGE_BITS      = 16,
  parameter int ANGLE_FRAC_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lsg_pkg::lsg_cmd_t              cmd,
  output lsg_pkg::lsg_sts_t              sts,
  input  logic                           cfg_we,
  input  logic [lsg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [RANGE_BITS-1:0]          in_range_mm,
  input  logic                           in_last_sample,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [lsg_pkg::GAUGE_W-1:0]    out_safety_level,
  output logic [lsg_pkg::WEIGHTED_W-1:0] out_nearest_weighted_mm
);
  import lsg_pkg::*;

  localparam int WGT_W  = ANGLE_FRAC_BITS + 3;
  localparam int WSUM_W = (ANGLE_FRAC_BITS + 4 > 18) ? ANGLE_FRAC_BITS + 4 : 18;
  localparam int MPROD_W = RANGE_BITS + WGT_W;
  localparam int PROD_W  = MPROD_W + 1;
  localparam logic [WSUM_W-1:0] WONE = WSUM_W'(1) << ANGLE_FRAC_BITS;
  localparam logic [WSUM_W-1:0] WMAX = (WSUM_W'(8) << ANGLE_FRAC_BITS) - WSUM_W'(1);
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (ANGLE_FRAC_BITS - 1);

  // configuration registers
  logic [15:0]        crit_r, safe_r;
  logic signed [15:0] start_r, end_r;
  logic [11:0]        step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crit_r  <= CRITICAL_RST;
      safe_r  <= SAFE_RST;
      start_r <= START_RST;
      end_r   <= END_RST;
      step_r  <= STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CRITICAL:    crit_r  <= cfg_wdata;
        CFG_SAFE:        safe_r  <= cfg_wdata;
        CFG_ANGLE_START: start_r <= $signed(cfg_wdata);
        CFG_ANGLE_END:   end_r   <= $signed(cfg_wdata);
        CFG_ANGLE_STEP:  step_r  <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // scan centre, floor of half the sum
  logic signed [16:0] csum;
  logic signed [15:0] centre_r;
  assign csum = $signed({start_r[15], start_r}) + $signed({end_r[15], end_r});

  always_ff @(posedge clk) begin
    centre_r <= csum[16:1];
  end

  // sample capture and beam angle, saturating upward
  logic [RANGE_BITS-1:0] range_r;
  logic                  last_r;
  logic                  first_r;
  logic signed [15:0]    angle_r, angle_nxt;
  logic signed [16:0]    angle_sum;

  assign angle_sum = $signed({angle_r[15], angle_r}) + $signed({5'b0, step_r});
  assign angle_nxt = first_r ? start_r :
                     (angle_sum > 17'sd32767) ? 16'sh7FFF : angle_sum[15:0];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      range_r <= in_range_mm;
      last_r  <= in_last_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
      first_r <= 1'b1;
    end else if (cmd.accept) begin
      angle_r <= angle_nxt;
      first_r <= 1'b0;
    end else if (cmd.load_out) begin
      first_r <= 1'b1;
    end
  end

  // distance from the centre
  logic signed [16:0] dsub;
  logic [16:0]        dneg;
  logic [15:0]        diff_r, diff_nxt;
  assign dsub     = $signed({angle_r[15], angle_r}) - $signed({centre_r[15], centre_r});
  assign dneg     = 17'(-dsub);
  assign diff_nxt = dsub[16] ? dneg[15:0] : dsub[15:0];

  always_ff @(posedge clk) begin
    if (cmd.diff_en) diff_r <= diff_nxt;
  end

  // weight 1 + (2/pi)*diff, saturated
  logic [31:0]       wprod;
  logic [32:0]       wrnd;
  logic [WSUM_W-1:0] wsum;
  logic [WGT_W-1:0]  weight_r, weight_nxt;
  assign wprod      = diff_r * TWO_OVER_PI_Q16;
  assign wrnd       = {1'b0, wprod} + 33'd32768;
  assign wsum       = WONE + WSUM_W'(wrnd[32:16]);
  assign weight_nxt = (wsum > WMAX) ? WMAX[WGT_W-1:0] : wsum[WGT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wgt_en) weight_r <= weight_nxt;
  end

  // weighted range, rounded and saturated
  logic [MPROD_W-1:0]    mprod;
  logic [PROD_W-1:0]     prod, shifted;
  logic [WEIGHTED_W-1:0] wtd_r, wtd_nxt;
  assign mprod   = range_r * weight_r;
  assign prod    = {1'b0, mprod} + HALF;
  assign shifted = prod >> ANGLE_FRAC_BITS;
  assign wtd_nxt = (shifted > PROD_W'(WEIGHTED_MAX)) ? WEIGHTED_MAX
                                                     : shifted[WEIGHTED_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mul_en) wtd_r <= wtd_nxt;
  end

  // running minimum of the scan
  logic [WEIGHTED_W-1:0] min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) min_r <= WEIGHTED_MAX;
    else if (cmd.load_out) min_r <= WEIGHTED_MAX;
    else if (cmd.min_en && (wtd_r < min_r)) min_r <= wtd_r;
  end

  // gauge cases that need no divide
  logic                  trivial;
  logic [GAUGE_W-1:0]    trivial_val;
  logic [WEIGHTED_W-1:0] crit_x, safe_x;
  assign crit_x = WEIGHTED_W'(crit_r);
  assign safe_x = WEIGHTED_W'(safe_r);

  always_comb begin
    trivial     = 1'b1;
    trivial_val = '0;
    if (safe_r <= crit_r) begin
      trivial_val = (min_r >= crit_x) ? GAUGE_MAX : '0;
    end else if (min_r <= crit_x) begin
      trivial_val = '0;
    end else if (min_r >= safe_x) begin
      trivial_val = GAUGE_MAX;
    end else begin
      trivial = 1'b0;
    end
  end

  // restoring divide, one quotient bit a cycle
  logic [15:0]        rem_r, dvs_r;
  logic [16:0]        rem2, rem_sub;
  logic               ge;
  logic [GAUGE_W-1:0] gauge_r;
  logic [3:0]         cnt_r;
  assign rem2    = {rem_r, 1'b0};
  assign rem_sub = rem2 - {1'b0, dvs_r};
  assign ge      = rem2 >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      if (trivial) begin
        gauge_r <= trivial_val;
      end else begin
        gauge_r <= '0;
        rem_r   <= min_r[15:0] - crit_r;
        dvs_r   <= safe_r - crit_r;
        cnt_r   <= DIV_STEPS_M1;
      end
    end else if (cmd.div_step) begin
      rem_r   <= ge ? rem_sub[15:0] : rem2[15:0];
      gauge_r <= {gauge_r[GAUGE_W-2:0], ge};
      cnt_r   <= cnt_r - 4'd1;
    end
  end

  // result register
  logic                  out_valid_r;
  logic [GAUGE_W-1:0]    out_gauge_r;
  logic [WEIGHTED_W-1:0] out_near_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.load_out) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_gauge_r <= gauge_r;
      out_near_r  <= min_r;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_safety_level        = out_gauge_r;
  assign out_nearest_weighted_mm = out_near_r;

  // status
  assign sts.last          = last_r;
  assign sts.gauge_trivial = trivial;
  assign sts.div_done      = (cnt_r == 4'd0);
  assign sts.out_busy      = out_valid_r && !out_ready;

endmodule

`default_nettype wire
